[rtl/srs_pkg.sv]
// Package for the selective-repeat sender: widths, codes and the structs that
// pass between the controller and the datapath.
// Depends on nothing; every other file of the block but srs_ram imports it.
package srs_pkg;

    // Fixed field widths of the channels.
    localparam int CHUNK_BYTES     = 3;
    localparam int DATA_W          = 8 * CHUNK_BYTES;
    localparam int SEQ_W           = 6;
    localparam int SEQ_REACH       = 1 << SEQ_W;
    localparam int ACTION_W        = 2;
    localparam int KIND_W          = 2;
    localparam int AGE_W           = 16;
    localparam int CC_W            = 7;
    localparam int TO_W            = 16;
    localparam int CFG_ADDR_W      = 1;
    localparam int CFG_DATA_W      = 16;
    localparam int CHUNK_SLOTS_DEF = 64;

    // Register reset values.
    localparam logic [CC_W-1:0]  CHUNK_COUNT_RST = CC_W'(1);
    localparam logic [TO_W-1:0]  TIMEOUT_RST     = TO_W'(100);
    localparam logic [AGE_W-1:0] AGE_MAX         = '1;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_CHUNK_COUNT = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TIMEOUT     = 1'b1;

    // Input actions.
    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_START = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ACK   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd3;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_SENT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESENT  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ACK_OK  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ACK_BAD = 2'd3;

    // One result item.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SEQ_W-1:0]  seq;
        logic [DATA_W-1:0] data;
        logic              all_acked;
        logic              last;
    } t_result;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // store the payload of a load transaction
        logic start;      // clear flags and ages, begin a send scan
        logic tick;       // begin a resend scan
        logic ack;        // set the flag of an acknowledgement, begin flag check
        logic scan_run;   // run the chunk scan pipeline
        logic flag_step;  // check one acknowledgement flag
        logic ack_emit;   // place the acknowledgement result
        logic flush;      // release the held result as the final one
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sending;
        logic scan_done;
        logic flag_done;
        logic pend_vld;
        logic out_free;
    } t_dp_status;

endpackage

[rtl/srs_if.sv]
// Channel interfaces of the selective-repeat sender: input items, results
// and configuration writes, each with valid and ready.
// Depends on srs_pkg for the field widths.
interface srs_item_if;
    import srs_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [SEQ_W-1:0]    seq;
    logic [DATA_W-1:0]   payload;

    modport source (output valid, output action, output seq, output payload, input ready);
    modport sink   (input valid, input action, input seq, input payload, output ready);
endinterface

interface srs_result_if;
    import srs_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] out_kind;
    logic [SEQ_W-1:0]  out_seq;
    logic [DATA_W-1:0] out_data;
    logic              all_acked;
    logic              last;

    modport source (output valid, output out_kind, output out_seq, output out_data,
                    output all_acked, output last, input ready);
    modport sink   (input valid, input out_kind, input out_seq, input out_data,
                    input all_acked, input last, output ready);
endinterface

interface srs_cfg_if;
    import srs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

[rtl/srs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module srs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[rtl/srs_ctrl.sv]
// Controller of the selective-repeat sender: sequences load, start, ack and
// tick transactions and drives the datapath commands.
// Depends on srs_pkg.
module srs_ctrl (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [srs_pkg::ACTION_W-1:0]   i_action,
    input  srs_pkg::t_dp_status            i_status,
    output logic                           o_ready,
    output srs_pkg::t_dp_cmd               o_cmd
);
    import srs_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_ACKCHK = 5'b00100,
        S_ACKOUT = 5'b01000,
        S_FLUSH  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   w_accept;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_action)
                        ACT_LOAD: begin
                            o_cmd.load = 1'b1;
                        end
                        ACT_START: begin
                            o_cmd.start = 1'b1;
                            n_state     = S_SCAN;
                        end
                        ACT_ACK: begin
                            o_cmd.ack = 1'b1;
                            n_state   = S_ACKCHK;
                        end
                        ACT_TICK: begin
                            // A tick while idle is taken and gives nothing.
                            if (i_status.sending) begin
                                o_cmd.tick = 1'b1;
                                n_state    = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_status.scan_done) begin
                    n_state = S_FLUSH;
                end
            end
            S_ACKCHK: begin
                o_cmd.flag_step = 1'b1;
                if (i_status.flag_done) begin
                    n_state = S_ACKOUT;
                end
            end
            S_ACKOUT: begin
                o_cmd.ack_emit = 1'b1;
                n_state        = S_FLUSH;
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                if (!i_status.pend_vld || i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end
endmodule

[rtl/srs_dp.sv]
// Datapath of the selective-repeat sender: configuration registers, chunk
// and age memories, acknowledgement flags, scan pipeline and result buffers.
// Depends on srs_pkg and srs_ram.
module srs_dp #(
    parameter int CHUNK_SLOTS = srs_pkg::CHUNK_SLOTS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  srs_pkg::t_dp_cmd                 i_cmd,
    output srs_pkg::t_dp_status              o_status,
    input  logic [srs_pkg::SEQ_W-1:0]        i_seq,
    input  logic [srs_pkg::DATA_W-1:0]       i_payload,
    input  logic                             i_cfg_we,
    input  logic [srs_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [srs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output srs_pkg::t_result                 o_res,
    output logic                             o_res_vld,
    input  logic                             i_res_ready
);
    import srs_pkg::*;

    localparam int ADDR_W = $clog2(CHUNK_SLOTS);
    localparam int CAP    = (CHUNK_SLOTS < SEQ_REACH) ? CHUNK_SLOTS : SEQ_REACH;
    localparam int CNT_W  = $clog2(CAP + 1);

    // Configuration.
    logic [CC_W-1:0]  r_cc;
    logic [TO_W-1:0]  r_timeout;
    logic [CNT_W-1:0] w_n;

    // Scan and flag state.
    logic [CNT_W-1:0]       r_cnt;
    logic [CNT_W-1:0]       r_ev_idx;
    logic                   r_ev_vld;
    logic                   r_mode_send;
    logic [CHUNK_SLOTS-1:0] r_acked;
    logic [CHUNK_SLOTS-1:0] r_age_vld;
    logic                   r_sending;
    logic                   r_acc;
    logic [SEQ_W-1:0]       r_ack_seq;
    logic                   r_ack_ok;

    // Result buffers.
    t_result r_pend, n_pend, r_out, n_out;
    logic    r_pend_vld, n_pend_vld, r_out_vld, n_out_vld;

    // Combinational signals.
    logic              w_issue, w_advance, w_ev_fire, w_emit, w_emit_ok, w_out_free;
    logic              w_ev_acked, w_due, w_age_we, w_ack_ok, w_chunk_we, w_cnt_more;
    logic [ADDR_W-1:0] w_ev_addr, w_rd_addr;
    logic [AGE_W-1:0]  w_age_rd, w_age_cur, w_age_inc, w_age_wd;
    logic [DATA_W-1:0] w_chunk_rd;
    t_result           w_new, w_ack_res;

    // Chunks in use: the count clamped to one at least and to the capacity at most.
    always_comb begin
        if (r_cc == '0) begin
            w_n = CNT_W'(1);
        end else if (32'(r_cc) > CAP) begin
            w_n = CNT_W'(CAP);
        end else begin
            w_n = CNT_W'(r_cc);
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc      <= CHUNK_COUNT_RST;
            r_timeout <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_CHUNK_COUNT: r_cc      <= i_cfg_data[CC_W-1:0];
                CFG_TIMEOUT:     r_timeout <= i_cfg_data[TO_W-1:0];
                default: ;
            endcase
        end
    end

    // Scan: one entry read per cycle unless stalled, evaluated the cycle after.
    assign w_cnt_more = (r_cnt < w_n);
    assign w_issue    = i_cmd.scan_run && w_cnt_more;
    assign w_ev_addr  = ADDR_W'(r_ev_idx);
    assign w_ev_acked = r_acked[w_ev_addr];
    assign w_age_cur  = r_age_vld[w_ev_addr] ? w_age_rd : '0;
    assign w_age_inc  = (w_age_cur == AGE_MAX) ? w_age_cur : w_age_cur + AGE_W'(1);
    assign w_due      = (w_age_inc >= r_timeout);
    assign w_emit     = r_mode_send || (!w_ev_acked && w_due);
    assign w_out_free = !r_out_vld || i_res_ready;
    assign w_emit_ok  = !r_pend_vld || w_out_free;
    assign w_ev_fire  = r_ev_vld && (!w_emit || w_emit_ok);
    assign w_advance  = i_cmd.scan_run && (!r_ev_vld || w_ev_fire);
    // While the evaluation stage waits, the read holds its address.
    assign w_rd_addr  = w_advance ? ADDR_W'(r_cnt) : w_ev_addr;
    assign w_age_we   = w_ev_fire && !r_mode_send && !w_ev_acked;
    assign w_age_wd   = w_due ? '0 : w_age_inc;

    assign w_ack_ok   = (CC_W'(i_seq) < CC_W'(w_n));
    assign w_chunk_we = i_cmd.load && (32'(i_seq) < CHUNK_SLOTS);

    assign w_new = '{kind:      (r_mode_send ? KIND_SENT : KIND_RESENT),
                     seq:       SEQ_W'(r_ev_idx),
                     data:      w_chunk_rd,
                     all_acked: 1'b0,
                     last:      1'b0};

    assign w_ack_res = '{kind:      (r_ack_ok ? KIND_ACK_OK : KIND_ACK_BAD),
                         seq:       r_ack_seq,
                         data:      '0,
                         all_acked: r_acc,
                         last:      1'b0};

    // Chunk store and age memories.
    srs_ram #(.WIDTH(DATA_W), .DEPTH(CHUNK_SLOTS)) u_chunk_ram (
        .i_clk   (i_clk),
        .i_we    (w_chunk_we),
        .i_waddr (ADDR_W'(i_seq)),
        .i_wdata (i_payload),
        .i_raddr (w_rd_addr),
        .o_rdata (w_chunk_rd)
    );

    srs_ram #(.WIDTH(AGE_W), .DEPTH(CHUNK_SLOTS)) u_age_ram (
        .i_clk   (i_clk),
        .i_we    (w_age_we),
        .i_waddr (w_ev_addr),
        .i_wdata (w_age_wd),
        .i_raddr (w_rd_addr),
        .o_rdata (w_age_rd)
    );

    // Counter, evaluation stage, flags and sending state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_ev_idx    <= '0;
            r_ev_vld    <= 1'b0;
            r_mode_send <= 1'b0;
            r_acked     <= '0;
            r_age_vld   <= '0;
            r_sending   <= 1'b0;
            r_acc       <= 1'b0;
        end else begin
            if (i_cmd.start || i_cmd.tick || i_cmd.ack) begin
                r_cnt    <= '0;
                r_ev_vld <= 1'b0;
            end else if (w_advance) begin
                r_ev_vld <= w_issue;
                r_ev_idx <= r_cnt;
                if (w_issue) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end else if (i_cmd.flag_step && w_cnt_more) begin
                r_cnt <= r_cnt + CNT_W'(1);
                r_acc <= r_acc && r_acked[ADDR_W'(r_cnt)];
            end

            if (i_cmd.start) begin
                r_mode_send <= 1'b1;
                r_acked     <= '0;
                r_age_vld   <= '0;
                r_sending   <= 1'b1;
            end
            if (i_cmd.tick) begin
                r_mode_send <= 1'b0;
            end
            if (i_cmd.ack) begin
                r_acc <= 1'b1;
                if (w_ack_ok) begin
                    r_acked[ADDR_W'(i_seq)] <= 1'b1;
                end
            end
            if (w_age_we) begin
                r_age_vld[w_ev_addr] <= 1'b1;
            end
            // The message is complete once every chunk in use is acknowledged.
            if (i_cmd.ack_emit && r_ack_ok && r_acc) begin
                r_sending <= 1'b0;
            end
        end
    end

    // Acknowledgement details held for the result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ack) begin
            r_ack_seq <= i_seq;
            r_ack_ok  <= w_ack_ok;
        end
    end

    // The newest result is held back until it is known whether it is the last.
    always_comb begin
        n_out      = r_out;
        n_out_vld  = r_out_vld && !i_res_ready;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        if (w_ev_fire && w_emit) begin
            if (r_pend_vld) begin
                n_out     = r_pend;
                n_out_vld = 1'b1;
            end
            n_pend     = w_new;
            n_pend_vld = 1'b1;
        end
        if (i_cmd.ack_emit) begin
            n_pend     = w_ack_res;
            n_pend_vld = 1'b1;
        end
        if (i_cmd.flush && r_pend_vld && w_out_free) begin
            n_out      = r_pend;
            n_out.last = 1'b1;
            n_out_vld  = 1'b1;
            n_pend_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_pend_vld <= n_pend_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_pend <= n_pend;
    end

    assign o_res     = r_out;
    assign o_res_vld = r_out_vld;

    assign o_status = '{sending:   r_sending,
                        scan_done: !w_cnt_more && !r_ev_vld,
                        flag_done: !w_cnt_more,
                        pend_vld:  r_pend_vld,
                        out_free:  w_out_free};
endmodule

[rtl/selective_repeat_sender.sv]
// Selective-repeat sender. Items arrive on i_item (action, seq, payload) and
// results leave on o_result (out_kind, out_seq, out_data, all_acked, last);
// both are valid/ready channels, a transaction completing when both are high.
// Registers chunk_count and timeout_ticks are written on i_cfg, always ready,
// and are to be written only while the block is idle.
// A load transaction gives no result. A start, an ack or a tick while sending
// works through the chunks in use: the chunk and age memories are read one
// entry per cycle while the receiver does not stall, and an ack checks one
// acknowledgement flag per cycle. The last result of an item carries last.
// The item channel is ready again once the final result sits in the output
// register, so the next item is taken while that result waits.
// When the receiver stalls, the scan pauses at the next chunk that needs a
// result slot and resumes without loss.
// Reset (synchronous, active low) clears all flags, ages, sending state and
// buffers at once and restores chunk_count to 1 and timeout_ticks to 100.
// Chunk contents are undefined until loaded.
module selective_repeat_sender #(
    parameter int CHUNK_SLOTS = srs_pkg::CHUNK_SLOTS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    srs_item_if.sink     i_item,
    srs_result_if.source o_result,
    srs_cfg_if.sink      i_cfg
);
    import srs_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_st;
    t_result    w_res;
    logic       w_res_vld;
    logic       w_ready;

    // Controller.
    srs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_item.valid),
        .i_action (i_item.action),
        .i_status (w_st),
        .o_ready  (w_ready),
        .o_cmd    (w_cmd)
    );

    // Datapath.
    srs_dp #(.CHUNK_SLOTS(CHUNK_SLOTS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_st),
        .i_seq       (i_item.seq),
        .i_payload   (i_item.payload),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_addr  (i_cfg.addr),
        .i_cfg_data  (i_cfg.data),
        .o_res       (w_res),
        .o_res_vld   (w_res_vld),
        .i_res_ready (o_result.ready)
    );

    // Channel wiring.
    assign i_item.ready       = w_ready;
    assign i_cfg.ready        = 1'b1;
    assign o_result.valid     = w_res_vld;
    assign o_result.out_kind  = w_res.kind;
    assign o_result.out_seq   = w_res.seq;
    assign o_result.out_data  = w_res.data;
    assign o_result.all_acked = w_res.all_acked;
    assign o_result.last      = w_res.last;

    // A new item is only taken once no result is held back.
    a_ready_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ready |-> !w_st.pend_vld)
        else $error("item channel ready while a result is held back");

    // The acknowledgement result is held the cycle after it is placed.
    a_ack_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.ack_emit |=> w_st.pend_vld)
        else $error("acknowledgement result not held");

    // Sent and resent chunks never report the message as complete.
    a_send_not_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_vld && (w_res.kind == KIND_SENT || w_res.kind == KIND_RESENT))
            |-> !w_res.all_acked)
        else $error("chunk result reports all acknowledged");

    // A start leaves the block sending.
    a_start_sends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.start |=> w_st.sending)
        else $error("sending not set after start");
endmodule
